### rtl/core/per_core_dvfs_thermal_controller_unit_assert.svh
// Assertion macros shared by the per-core DVFS controller RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef PER_CORE_DVFS_THERMAL_CONTROLLER_UNIT_ASSERT_SVH
`define PER_CORE_DVFS_THERMAL_CONTROLLER_UNIT_ASSERT_SVH

`ifndef SYNTH
`define PDTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PDTC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PDTC_ASSERT(lbl, prop, msg)
`define PDTC_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

### rtl/core/pdtc_pkg.sv
// Types, constants and helpers for the per-core DVFS thermal controller.
// No dependencies.
`default_nettype none

package pdtc_pkg;

  localparam int CORE_COUNT_DEF = 8;

  localparam int OP_W      = 3;
  localparam int CORE_W    = 3;
  localparam int VAL_W     = 18;
  localparam int FREQ_W    = 13;
  localparam int POW_W     = 13;
  localparam int CS_W      = 3;
  localparam int GOV_W     = 3;
  localparam int TEMP_W    = 18;
  localparam int ACT_W     = 4;
  localparam int ST_W      = 2;
  localparam int LVL_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 18;
  localparam int PCT_W     = 7;

  localparam int DIVIDEND_W = 26;
  localparam int DIVISOR_W  = 13;

  // floor(x / 100) == (x * PCT_RECIP) >> RECIP_SH for every x below 2^20
  localparam int KEEP_MUL_W = 28;
  localparam int RECIP_SH   = 27;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [POW_W-1:0]  power;
    logic [CS_W-1:0]   cstate;
    logic              online;
    logic [GOV_W-1:0]  gov;
    logic [TEMP_W-1:0] temp;
  } rec_t;

  localparam rec_t REC_RESET = '{
    freq:   FREQ_W'(2400),
    power:  POW_W'(3500),
    cstate: CS_W'(0),
    online: 1'b1,
    gov:    GOV_W'(3),
    temp:   TEMP_W'(45000)
  };

  typedef enum logic [OP_W-1:0] {
    OP_SET_FREQ    = 3'd0,
    OP_GOVERNOR    = 3'd1,
    OP_CSTATE      = 3'd2,
    OP_HOTPLUG_OFF = 3'd3,
    OP_HOTPLUG_ON  = 3'd4,
    OP_THERMAL     = 3'd5,
    OP_READ        = 3'd6
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_CORES = 3'd0,
    CFG_MIN_FREQ     = 3'd1,
    CFG_MAX_FREQ     = 3'd2,
    CFG_WARN_TEMP    = 3'd3,
    CFG_CRIT_TEMP    = 3'd4
  } cfg_idx_e;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [ST_W-1:0] ST_REFUSED = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD     = 2'd3;

  localparam logic [LVL_W-1:0] LVL_NONE = 2'd0;
  localparam logic [LVL_W-1:0] LVL_WARN = 2'd1;
  localparam logic [LVL_W-1:0] LVL_CRIT = 2'd2;

  localparam logic [GOV_W-1:0] GOV_CODE_MAXF = 3'd0;
  localparam logic [GOV_W-1:0] GOV_CODE_MINF = 3'd1;
  localparam logic [VAL_W-1:0] GOV_MAX       = 18'd5;

  localparam logic [CS_W-1:0]  CS_C0  = 3'd0;
  localparam logic [CS_W-1:0]  CS_C3  = 3'd3;
  localparam logic [CS_W-1:0]  CS_C8  = 3'd5;
  localparam logic [VAL_W-1:0] CS_MAX = 18'd5;

  localparam logic [ACT_W-1:0]  RST_ACTIVE_CORES = 4'd8;
  localparam logic [FREQ_W-1:0] RST_MIN_FREQ     = 13'd400;
  localparam logic [FREQ_W-1:0] RST_MAX_FREQ     = 13'd4800;
  localparam logic [TEMP_W-1:0] RST_WARN_TEMP    = 18'd80000;
  localparam logic [TEMP_W-1:0] RST_CRIT_TEMP    = 18'd95000;

  localparam logic [FREQ_W-1:0] POWER_SCALE = 13'd5000;
  localparam logic [PCT_W-1:0]  PCT_FULL    = 7'd100;

  localparam logic [PCT_W-1:0] CS_REDUCTION [6] = '{7'd0, 7'd10, 7'd30, 7'd60, 7'd90, 7'd95};

  localparam logic [KEEP_MUL_W-1:0] PCT_RECIP = 28'd1342178;

  // kept percentage per C-state, premultiplied by the reciprocal of 100
  localparam logic [KEEP_MUL_W-1:0] CS_KEEP_MUL [6] = '{
    KEEP_MUL_W'(32'(PCT_FULL - CS_REDUCTION[0]) * 32'(PCT_RECIP)),
    KEEP_MUL_W'(32'(PCT_FULL - CS_REDUCTION[1]) * 32'(PCT_RECIP)),
    KEEP_MUL_W'(32'(PCT_FULL - CS_REDUCTION[2]) * 32'(PCT_RECIP)),
    KEEP_MUL_W'(32'(PCT_FULL - CS_REDUCTION[3]) * 32'(PCT_RECIP)),
    KEEP_MUL_W'(32'(PCT_FULL - CS_REDUCTION[4]) * 32'(PCT_RECIP)),
    KEEP_MUL_W'(32'(PCT_FULL - CS_REDUCTION[5]) * 32'(PCT_RECIP))
  };

  // Scale factor for the power kept after entering C-state s.
  function automatic logic [KEEP_MUL_W-1:0] cs_keep_mul(input logic [CS_W-1:0] s);
    return CS_KEEP_MUL[s];
  endfunction

endpackage

`default_nettype wire

### rtl/core/pdtc_mem.sv
// Per-core record memory: one write port, one registered read port.
// Entries read as the reset record until first written. Uses pdtc_pkg.
`default_nettype none

module pdtc_mem #(
  parameter int CORE_COUNT = pdtc_pkg::CORE_COUNT_DEF,
  parameter int IDX_W      = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [IDX_W-1:0]  rd_addr_i,
  output pdtc_pkg::rec_t    rd_data_o,
  input  logic              wr_en_i,
  input  logic [IDX_W-1:0]  wr_addr_i,
  input  pdtc_pkg::rec_t    wr_data_i
);
  import pdtc_pkg::*;

  rec_t                  mem [CORE_COUNT];
  logic [CORE_COUNT-1:0] valid_q;
  rec_t                  rd_rec_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_rec_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_rec_q : REC_RESET;

endmodule

`default_nettype wire

### rtl/core/pdtc_div.sv
// Restoring divider, one quotient bit per cycle, for the power model.
// Uses pdtc_pkg widths. Divisor must be nonzero.
`default_nettype none
`include "per_core_dvfs_thermal_controller_unit_assert.svh"

module pdtc_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [pdtc_pkg::DIVIDEND_W-1:0]     dividend_i,
  input  logic [pdtc_pkg::DIVISOR_W-1:0]      divisor_i,
  output logic                                busy_o,
  output logic                                done_o,
  output logic [pdtc_pkg::DIVIDEND_W-1:0]     quotient_o
);
  import pdtc_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q;
  logic                  done_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  dvs_q;

  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_sub;
  logic                  fits;

  assign rem_sh  = {rem_q, quo_q[DIVIDEND_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign fits    = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIVIDEND_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
      rem_q <= fits ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  `PDTC_ASSERT_NEVER(a_div_start_busy, start_i && busy_q, "divider restarted while busy")
  `PDTC_ASSERT(a_div_start_runs, start_i |=> busy_q && cnt_q == CNT_W'(DIVIDEND_W), "no run")
  `PDTC_ASSERT_NEVER(a_div_done_busy, done_q && busy_q, "done while still iterating")

endmodule

`default_nettype wire

### rtl/core/per_core_dvfs_thermal_controller_unit.sv
// Path from input transaction to result: S_LOAD, S_WB, output register without a power update;
// a C-state entry adds S_SCALE, a divide by max_frequency adds S_MUL and S_DIV, a critical
// thermal update adds all three. One request in flight; the divider runs 26 bit-serial steps.
// The next request is taken once the result sits in the output register.
// Async active-low reset restores config registers and marks every core record unwritten.
// Top level; uses pdtc_pkg, pdtc_mem, pdtc_div.
`default_nettype none
`include "per_core_dvfs_thermal_controller_unit_assert.svh"

module per_core_dvfs_thermal_controller_unit #(
  parameter int CORE_COUNT = pdtc_pkg::CORE_COUNT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [pdtc_pkg::OP_W-1:0]         opcode_i,
  input  logic [pdtc_pkg::CORE_W-1:0]       core_index_i,
  input  logic [pdtc_pkg::VAL_W-1:0]        operand_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pdtc_pkg::ST_W-1:0]         status_o,
  output logic [pdtc_pkg::LVL_W-1:0]        throttle_level_o,
  output logic [pdtc_pkg::FREQ_W-1:0]       frequency_out_o,
  output logic [pdtc_pkg::POW_W-1:0]        power_out_o,
  output logic [pdtc_pkg::CS_W-1:0]         cstate_out_o,
  output logic                              online_out_o,
  output logic [pdtc_pkg::GOV_W-1:0]        governor_out_o,
  input  logic                              cfg_we_i,
  input  logic [pdtc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pdtc_pkg::CFG_DAT_W-1:0]    cfg_wdata_i
);
  import pdtc_pkg::*;

  localparam int IDX_W = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
  localparam logic [6:0] CORE_LIM = 7'(CORE_COUNT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_DIV,
    S_SCALE,
    S_WB
  } state_e;

  // config
  logic [ACT_W-1:0]  active_q;
  logic [FREQ_W-1:0] min_q;
  logic [FREQ_W-1:0] max_q;
  logic [TEMP_W-1:0] warn_q;
  logic [TEMP_W-1:0] crit_q;

  state_e             state_q, state_d;
  logic [OP_W-1:0]    op_q, op_d;
  logic [CORE_W-1:0]  core_q, core_d;
  logic [VAL_W-1:0]   val_q, val_d;
  logic [IDX_W-1:0]   addr_q, addr_d;
  rec_t               rec_q, rec_d;
  logic [ST_W-1:0]    status_q, status_d;
  logic [LVL_W-1:0]   level_q, level_d;
  logic               wr_q, wr_d;
  logic               scale_q, scale_d;
  logic [KEEP_MUL_W-1:0] keep_q, keep_d;
  logic [FREQ_W-1:0]  mul_a_q, mul_a_d;
  logic [FREQ_W-1:0]  mul_b_q, mul_b_d;
  logic [DIVISOR_W-1:0] div_by_q, div_by_d;
  logic               out_valid_q, out_valid_d;
  logic [ST_W-1:0]    out_status_q, out_status_d;
  logic [LVL_W-1:0]   out_level_q, out_level_d;
  rec_t               out_rec_q, out_rec_d;

  logic                    in_fire;
  logic [IDX_W+CORE_W-1:0] in_addr_ext;
  rec_t                    mem_rd_rec;
  logic                    mem_we;
  logic                    div_start;
  logic                    div_busy;
  logic                    div_done;
  logic [DIVIDEND_W-1:0]   div_quo;
  logic [DIVIDEND_W-1:0]   product;
  logic [POW_W+KEEP_MUL_W-1:0] scaled;
  logic [FREQ_W:0]         mid_sum;

  function automatic logic [FREQ_W-1:0] clamp_freq(input logic [VAL_W-1:0]  v,
                                                   input logic [FREQ_W-1:0] lo,
                                                   input logic [FREQ_W-1:0] hi);
    logic [VAL_W-1:0] t;
    t = (v < VAL_W'(lo)) ? VAL_W'(lo) : v;
    return (t > VAL_W'(hi)) ? hi : t[FREQ_W-1:0];
  endfunction

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign in_addr_ext = (IDX_W+CORE_W)'(core_index_i);
  assign product     = DIVIDEND_W'(mul_a_q) * DIVIDEND_W'(mul_b_q);
  assign scaled      = (POW_W+KEEP_MUL_W)'(mul_a_q) * (POW_W+KEEP_MUL_W)'(keep_q);
  assign mid_sum     = {1'b0, min_q} + {1'b0, max_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= RST_ACTIVE_CORES;
      min_q    <= RST_MIN_FREQ;
      max_q    <= RST_MAX_FREQ;
      warn_q   <= RST_WARN_TEMP;
      crit_q   <= RST_CRIT_TEMP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ACTIVE_CORES: active_q <= cfg_wdata_i[ACT_W-1:0];
        CFG_MIN_FREQ:     min_q    <= cfg_wdata_i[FREQ_W-1:0];
        CFG_MAX_FREQ:     max_q    <= cfg_wdata_i[FREQ_W-1:0];
        CFG_WARN_TEMP:    warn_q   <= cfg_wdata_i[TEMP_W-1:0];
        CFG_CRIT_TEMP:    crit_q   <= cfg_wdata_i[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic             in_range;
    logic             pow_calc;
    logic [FREQ_W-1:0] f_new;

    state_d      = state_q;
    op_d         = op_q;
    core_d       = core_q;
    val_d        = val_q;
    addr_d       = addr_q;
    rec_d        = rec_q;
    status_d     = status_q;
    level_d      = level_q;
    wr_d         = wr_q;
    scale_d      = scale_q;
    keep_d       = keep_q;
    mul_a_d      = mul_a_q;
    mul_b_d      = mul_b_q;
    div_by_d     = div_by_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_level_d  = out_level_q;
    out_rec_d    = out_rec_q;
    mem_we       = 1'b0;
    div_start    = 1'b0;
    in_range     = 1'b0;
    pow_calc     = 1'b0;
    f_new        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d    = opcode_i;
          core_d  = core_index_i;
          val_d   = operand_value_i;
          addr_d  = in_addr_ext[IDX_W-1:0];
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        in_range = ({1'b0, core_q} < active_q) && ({4'b0, core_q} < CORE_LIM);
        rec_d    = mem_rd_rec;
        status_d = ST_OK;
        level_d  = LVL_NONE;
        wr_d     = 1'b1;
        scale_d  = 1'b0;
        state_d  = S_WB;
        if (!in_range) begin
          rec_d    = '0;
          status_d = ST_RANGE;
          wr_d     = 1'b0;
        end else begin
          unique case (op_e'(op_q))
            OP_SET_FREQ: begin
              f_new      = clamp_freq(val_q, min_q, max_q);
              rec_d.freq = f_new;
              pow_calc   = 1'b1;
            end
            OP_GOVERNOR: begin
              if (val_q > GOV_MAX) begin
                status_d = ST_BAD;
              end else begin
                rec_d.gov = val_q[GOV_W-1:0];
                if (val_q[GOV_W-1:0] == GOV_CODE_MAXF) rec_d.freq = max_q;
                if (val_q[GOV_W-1:0] == GOV_CODE_MINF) rec_d.freq = min_q;
              end
            end
            OP_CSTATE: begin
              if (val_q > CS_MAX) begin
                status_d = ST_BAD;
              end else begin
                rec_d.cstate = val_q[CS_W-1:0];
                keep_d       = cs_keep_mul(val_q[CS_W-1:0]);
                scale_d      = 1'b1;
              end
            end
            OP_HOTPLUG_OFF: begin
              if (core_q == '0) begin
                status_d = ST_REFUSED;
              end else begin
                rec_d.online = 1'b0;
                rec_d.cstate = CS_C8;
                rec_d.power  = '0;
              end
            end
            OP_HOTPLUG_ON: begin
              rec_d.online = 1'b1;
              rec_d.cstate = CS_C0;
              rec_d.freq   = min_q;
            end
            OP_THERMAL: begin
              rec_d.temp = val_q;
              if (val_q > crit_q) begin
                f_new        = clamp_freq(VAL_W'(min_q), min_q, max_q);
                rec_d.freq   = f_new;
                rec_d.cstate = CS_C3;
                keep_d       = cs_keep_mul(CS_C3);
                scale_d      = 1'b1;
                pow_calc     = 1'b1;
                level_d      = LVL_CRIT;
              end else if (val_q > warn_q) begin
                f_new      = clamp_freq(VAL_W'(mid_sum[FREQ_W:1]), min_q, max_q);
                rec_d.freq = f_new;
                pow_calc   = 1'b1;
                level_d    = LVL_WARN;
              end
            end
            OP_READ: ;
            default: status_d = ST_BAD;
          endcase

          if (pow_calc) begin
            if (max_q == '0) begin
              // zero power stays zero through any C-state scaling
              rec_d.power = '0;
              scale_d     = 1'b0;
            end else begin
              mul_a_d  = f_new;
              mul_b_d  = POWER_SCALE;
              div_by_d = max_q;
              state_d  = S_MUL;
            end
          end else if (scale_d) begin
            mul_a_d = mem_rd_rec.power;
            scale_d = 1'b0;
            state_d = S_SCALE;
          end
        end
      end
      S_MUL: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          rec_d.power = div_quo[POW_W-1:0];
          if (scale_q) begin
            mul_a_d = div_quo[FREQ_W-1:0];
            scale_d = 1'b0;
            state_d = S_SCALE;
          end else begin
            state_d = S_WB;
          end
        end
      end
      S_SCALE: begin
        rec_d.power = scaled[RECIP_SH +: POW_W];
        state_d     = S_WB;
      end
      S_WB: begin
        if (!out_valid_q || out_ready_i) begin
          mem_we       = wr_q;
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_level_d  = level_q;
          out_rec_d    = rec_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= '0;
      core_q       <= '0;
      val_q        <= '0;
      addr_q       <= '0;
      rec_q        <= '0;
      status_q     <= ST_OK;
      level_q      <= LVL_NONE;
      wr_q         <= 1'b0;
      scale_q      <= 1'b0;
      keep_q       <= '0;
      mul_a_q      <= '0;
      mul_b_q      <= '0;
      div_by_q     <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_level_q  <= LVL_NONE;
      out_rec_q    <= '0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      core_q       <= core_d;
      val_q        <= val_d;
      addr_q       <= addr_d;
      rec_q        <= rec_d;
      status_q     <= status_d;
      level_q      <= level_d;
      wr_q         <= wr_d;
      scale_q      <= scale_d;
      keep_q       <= keep_d;
      mul_a_q      <= mul_a_d;
      mul_b_q      <= mul_b_d;
      div_by_q     <= div_by_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_level_q  <= out_level_d;
      out_rec_q    <= out_rec_d;
    end
  end

  pdtc_mem #(
    .CORE_COUNT (CORE_COUNT),
    .IDX_W      (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (in_addr_ext[IDX_W-1:0]),
    .rd_data_o (mem_rd_rec),
    .wr_en_i   (mem_we),
    .wr_addr_i (addr_q),
    .wr_data_i (rec_q)
  );

  pdtc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product),
    .divisor_i  (div_by_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign throttle_level_o = out_level_q;
  assign frequency_out_o  = out_rec_q.freq;
  assign power_out_o      = out_rec_q.power;
  assign cstate_out_o     = out_rec_q.cstate;
  assign online_out_o     = out_rec_q.online;
  assign governor_out_o   = out_rec_q.gov;

  `PDTC_ASSERT(a_accept_loads, in_fire |=> state_q == S_LOAD, "accepted request not loaded")
  `PDTC_ASSERT(a_wb_slot_free, mem_we |-> !out_valid_q || out_ready_i, "write back with slot full")
  `PDTC_ASSERT(a_div_in_div, div_done |-> state_q == S_DIV && !div_busy, "stray divider result")
  `PDTC_ASSERT(a_range_zero, out_valid_q && out_status_q == ST_RANGE |-> out_rec_q == '0, "range")

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for per_core_dvfs_thermal_controller_unit: directed and random
// requests against a per-core power record predictor, with random idling and back-pressure.
// Depends on pdtc_pkg and the unit RTL.
`timescale 1ns / 100ps

module tb_top;
  import pdtc_pkg::*;

  localparam int CORE_COUNT      = CORE_COUNT_DEF;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int TAIL_CYCLES     = 80;
  localparam int POWER_FULL_MW   = 5000;

  localparam logic [OP_W-1:0]      OP_UNDEFINED     = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = 3'd5;
  localparam logic [GOV_W-1:0]     GOV_CODE_RESET   = 3'd3;
  // percent of power kept per C-state, C-state 0 in the low slice
  localparam logic [6*PCT_W-1:0]   CSTATE_KEEP =
      {7'd5, 7'd10, 7'd40, 7'd70, 7'd90, 7'd100};

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [LVL_W-1:0]  level;
    logic [FREQ_W-1:0] freq;
    logic [POW_W-1:0]  power;
    logic [CS_W-1:0]   cstate;
    logic              online;
    logic [GOV_W-1:0]  gov;
  } dvfs_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [OP_W-1:0]      opcode_i = '0;
  logic [CORE_W-1:0]    core_index_i = '0;
  logic [VAL_W-1:0]     operand_value_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [ST_W-1:0]      status_o;
  logic [LVL_W-1:0]     throttle_level_o;
  logic [FREQ_W-1:0]    frequency_out_o;
  logic [POW_W-1:0]     power_out_o;
  logic [CS_W-1:0]      cstate_out_o;
  logic                 online_out_o;
  logic [GOV_W-1:0]     governor_out_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata_i = '0;

  rec_t             core_rec [CORE_COUNT];
  logic [ACT_W-1:0] cfg_active;
  logic [FREQ_W-1:0] cfg_fmin;
  logic [FREQ_W-1:0] cfg_fmax;
  logic [TEMP_W-1:0] cfg_warn;
  logic [TEMP_W-1:0] cfg_crit;

  dvfs_result_t expected_results [$];
  int           mismatch_count = 0;
  int           quiet_cycles = 0;
  bit           sender_gaps = 1'b0;
  int           burst_left = 0;
  int           stall_pct = 0;
  int           hold_off_asks = 0;
  int           hold_off_done = 0;

  per_core_dvfs_thermal_controller_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .core_index_i     (core_index_i),
    .operand_value_i  (operand_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .throttle_level_o (throttle_level_o),
    .frequency_out_o  (frequency_out_o),
    .power_out_o      (power_out_o),
    .cstate_out_o     (cstate_out_o),
    .online_out_o     (online_out_o),
    .governor_out_o   (governor_out_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void retune_core(input int k, input int unsigned f);
    if (f < cfg_fmin) f = cfg_fmin;
    if (f > cfg_fmax) f = cfg_fmax;
    core_rec[k].freq = FREQ_W'(f);
    if (cfg_fmax == 0) core_rec[k].power = '0;
    else core_rec[k].power = POW_W'(f * POWER_FULL_MW / cfg_fmax);
  endfunction

  function automatic void enter_cstate(input int k, input logic [CS_W-1:0] s);
    int unsigned keep_pct;
    keep_pct = CSTATE_KEEP[s*PCT_W +: PCT_W];
    core_rec[k].cstate = s;
    core_rec[k].power = POW_W'(core_rec[k].power * keep_pct / 100);
  endfunction

  function automatic dvfs_result_t predict_response(input logic [OP_W-1:0] op,
      input logic [CORE_W-1:0] k, input logic [VAL_W-1:0] v);
    dvfs_result_t r;
    r = '0;
    if (k >= cfg_active || k >= CORE_COUNT) begin
      r.status = ST_RANGE;
      return r;
    end
    r.status = ST_OK;
    r.level = LVL_NONE;
    case (op)
      OP_SET_FREQ: retune_core(k, v);
      OP_GOVERNOR: begin
        if (v > GOV_MAX) begin
          r.status = ST_BAD;
        end else begin
          core_rec[k].gov = GOV_W'(v);
          if (v == GOV_CODE_MAXF) core_rec[k].freq = cfg_fmax;
          if (v == GOV_CODE_MINF) core_rec[k].freq = cfg_fmin;
        end
      end
      OP_CSTATE: begin
        if (v > CS_MAX) r.status = ST_BAD;
        else enter_cstate(k, CS_W'(v));
      end
      OP_HOTPLUG_OFF: begin
        if (k == 0) begin
          r.status = ST_REFUSED;
        end else begin
          core_rec[k].online = 1'b0;
          core_rec[k].cstate = CS_C8;
          core_rec[k].power = '0;
        end
      end
      OP_HOTPLUG_ON: begin
        core_rec[k].online = 1'b1;
        core_rec[k].cstate = CS_C0;
        core_rec[k].freq = cfg_fmin;
      end
      OP_THERMAL: begin
        core_rec[k].temp = v;
        if (v > cfg_crit) begin
          retune_core(k, cfg_fmin);
          enter_cstate(k, CS_C3);
          r.level = LVL_CRIT;
        end else if (v > cfg_warn) begin
          retune_core(k, (32'(cfg_fmin) + 32'(cfg_fmax)) / 2);
          r.level = LVL_WARN;
        end
      end
      OP_READ: ;
      default: r.status = ST_BAD;
    endcase
    r.freq = core_rec[k].freq;
    r.power = core_rec[k].power;
    r.cstate = core_rec[k].cstate;
    r.online = core_rec[k].online;
    r.gov = core_rec[k].gov;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input dvfs_result_t want,
      input dvfs_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $write("%0t %s: exp st=%0d lvl=%0d f=%0d p=%0d cs=%0d on=%0d gov=%0d", $time, what,
             want.status, want.level, want.freq, want.power, want.cstate, want.online,
             want.gov);
      $display(" | got st=%0d lvl=%0d f=%0d p=%0d cs=%0d on=%0d gov=%0d", got.status,
               got.level, got.freq, got.power, got.cstate, got.online, got.gov);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    dvfs_result_t got;
    dvfs_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {status_o, throttle_level_o, frequency_out_o, power_out_o, cstate_out_o,
             online_out_o, governor_out_o};
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) report_mismatch("result mismatch", want, got);
      end
    end
  end

  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (hold_off_asks != hold_off_done) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_done = hold_off_asks;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("per_core_dvfs_thermal_controller_unit: mismatch");
      $finish;
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [CORE_W-1:0] core,
      input logic [VAL_W-1:0] val);
    int gap;
    int roll;
    gap = 0;
    if (sender_gaps && burst_left <= 0) begin
      burst_left = $urandom_range(1, 20);
      roll = $urandom_range(0, 99);
      if (roll < 20) gap = 0;
      else if (roll < 85) gap = $urandom_range(1, 8);
      else gap = $urandom_range(9, 70);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    core_index_i <= core;
    operand_value_i <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_results.push_back(predict_response(op, core, val));
  endtask

  task automatic send_random_request();
    logic [OP_W-1:0]   op;
    logic [CORE_W-1:0] core;
    logic [VAL_W-1:0]  val;
    logic [TEMP_W-1:0] edge_level;
    int                roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) op = OP_SET_FREQ;
    else if (roll < 37) op = OP_GOVERNOR;
    else if (roll < 52) op = OP_CSTATE;
    else if (roll < 58) op = OP_HOTPLUG_OFF;
    else if (roll < 66) op = OP_HOTPLUG_ON;
    else if (roll < 86) op = OP_THERMAL;
    else if (roll < 97) op = OP_READ;
    else op = OP_UNDEFINED;
    if (cfg_active != 0 && $urandom_range(0, 99) < 88) begin
      if (cfg_active >= CORE_COUNT) core = CORE_W'($urandom_range(0, CORE_COUNT - 1));
      else core = CORE_W'($urandom_range(0, cfg_active - 1));
    end else begin
      core = CORE_W'($urandom);
    end
    val = VAL_W'($urandom);
    roll = $urandom_range(0, 99);
    case (op)
      OP_SET_FREQ: begin
        if (roll < 65) val = VAL_W'($urandom_range(0, (1 << FREQ_W) - 1));
        else if (roll < 85)
          val = VAL_W'(($urandom_range(0, 1) ? cfg_fmin : cfg_fmax) + $urandom_range(0, 2) - 1);
      end
      OP_GOVERNOR: begin
        if (roll < 85) val = VAL_W'($urandom_range(0, GOV_MAX));
        else if (roll < 92) val = GOV_MAX + VAL_W'(1);
      end
      OP_CSTATE: begin
        if (roll < 85) val = VAL_W'($urandom_range(0, CS_MAX));
        else if (roll < 92) val = CS_MAX + VAL_W'(1);
      end
      OP_THERMAL: begin
        edge_level = $urandom_range(0, 1) ? cfg_warn : cfg_crit;
        if (roll < 55) val = VAL_W'(edge_level + $urandom_range(0, 6) - 3);
        else if (roll < 85) val = VAL_W'($urandom_range(0, 120000));
      end
      default: ;
    endcase
    send_request(op, core, val);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // only called with the unit idle; bits above each register's width carry junk
  task automatic program_limits(input logic [ACT_W-1:0] active, input logic [FREQ_W-1:0] fmin,
      input logic [FREQ_W-1:0] fmax, input logic [TEMP_W-1:0] warn,
      input logic [TEMP_W-1:0] crit);
    logic [CFG_DAT_W-1:0] junk;
    junk = CFG_DAT_W'($urandom);
    write_reg(CFG_UNUSED_FIRST + CFG_IDX_W'($urandom_range(0, 2)), junk);
    junk = CFG_DAT_W'($urandom);
    junk[ACT_W-1:0] = active;
    write_reg(CFG_ACTIVE_CORES, junk);
    junk = CFG_DAT_W'($urandom);
    junk[FREQ_W-1:0] = fmin;
    write_reg(CFG_MIN_FREQ, junk);
    junk = CFG_DAT_W'($urandom);
    junk[FREQ_W-1:0] = fmax;
    write_reg(CFG_MAX_FREQ, junk);
    write_reg(CFG_WARN_TEMP, warn);
    write_reg(CFG_CRIT_TEMP, crit);
    cfg_we_i <= 1'b0;
    cfg_active = active;
    cfg_fmin = fmin;
    cfg_fmax = fmax;
    cfg_warn = warn;
    cfg_crit = crit;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input int count);
    repeat (count) send_random_request();
    settle();
  endtask

  task automatic test_reset_state();
    sender_gaps = 1'b0;
    stall_pct = 0;
    send_request(OP_READ, 0, '0);
    send_request(OP_READ, CORE_COUNT - 1, '1);
    settle();
  endtask

  task automatic test_directed_ops();
    sender_gaps = 1'b1;
    stall_pct = 30;
    send_request(OP_SET_FREQ, 1, '0);
    send_request(OP_SET_FREQ, 2, '1);
    send_request(OP_SET_FREQ, 3, 8191);
    send_request(OP_GOVERNOR, 3, VAL_W'(GOV_CODE_MAXF));
    send_request(OP_GOVERNOR, 4, VAL_W'(GOV_CODE_MINF));
    send_request(OP_GOVERNOR, 5, GOV_MAX);
    send_request(OP_GOVERNOR, 5, GOV_MAX + VAL_W'(1));
    send_request(OP_CSTATE, 1, CS_MAX);
    send_request(OP_CSTATE, 2, VAL_W'(CS_C3));
    send_request(OP_CSTATE, 2, VAL_W'(CS_C0));
    send_request(OP_CSTATE, 6, CS_MAX + VAL_W'(1));
    send_request(OP_HOTPLUG_OFF, 0, '1);
    send_request(OP_HOTPLUG_OFF, 7, '0);
    send_request(OP_CSTATE, 7, VAL_W'(CS_C3));
    send_request(OP_HOTPLUG_ON, 7, '0);
    send_request(OP_THERMAL, 1, cfg_warn);
    send_request(OP_THERMAL, 1, cfg_warn + TEMP_W'(1));
    send_request(OP_THERMAL, 2, cfg_crit);
    send_request(OP_THERMAL, 2, cfg_crit + TEMP_W'(1));
    send_request(OP_THERMAL, 3, '1);
    send_request(OP_THERMAL, 4, '0);
    send_request(OP_UNDEFINED, 5, '0);
    send_request(OP_READ, 7, '1);
    settle();
  endtask

  task automatic test_config_extremes();
    sender_gaps = 1'b1;
    stall_pct = 20;
    program_limits(1, 1, 8191, 0, 262143);
    run_phase(30);
    program_limits(0, 400, 4800, 80000, 95000);
    run_phase(20);
    program_limits(15, 8191, 8191, 262143, 262143);
    run_phase(30);
    program_limits(8, 5000, 1000, 50000, 40000);
    run_phase(30);
    program_limits(8, 0, 0, 0, 0);
    run_phase(30);
    program_limits(8, 300, 0, 70000, 90000);
    run_phase(30);
    program_limits(8, 400, 4800, 80000, 95000);
    run_phase(30);
  endtask

  // receiver holds off while the sender keeps offering: input must stall
  task automatic test_result_backpressure();
    sender_gaps = 1'b0;
    stall_pct = 0;
    hold_off_asks++;
    run_phase(50);
  endtask

  task automatic test_drain_pause();
    sender_gaps = 1'b1;
    stall_pct = 40;
    run_phase(30);
    run_phase(30);
  endtask

  task automatic test_random_traffic();
    int unsigned fmin;
    int unsigned fmax;
    int unsigned warn;
    int unsigned crit;
    int unsigned swap;
    for (int p = 0; p < 6; p++) begin
      sender_gaps = (p % 3 != 0);
      stall_pct = (p % 3 == 0) ? 0 : $urandom_range(10, 60);
      if (p == 0) begin
        program_limits(8, 400, 4800, 80000, 95000);
      end else begin
        fmin = $urandom_range(1, 4000);
        fmax = $urandom_range(fmin, 8191);
        warn = $urandom_range(30000, 100000);
        crit = warn + $urandom_range(0, 30000);
        if ($urandom_range(0, 99) < 15) begin
          swap = fmin;
          fmin = fmax;
          fmax = swap;
        end
        program_limits(ACT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
                                                         : $urandom_range(1, 8)),
                       FREQ_W'(fmin), FREQ_W'(fmax), TEMP_W'(warn), TEMP_W'(crit));
      end
      run_phase(250);
    end
  endtask

  initial begin : stimulus
    cfg_active = 4'd8;
    cfg_fmin = 13'd400;
    cfg_fmax = 13'd4800;
    cfg_warn = 18'd80000;
    cfg_crit = 18'd95000;
    for (int k = 0; k < CORE_COUNT; k++) begin
      core_rec[k].freq = 13'd2400;
      core_rec[k].power = 13'd3500;
      core_rec[k].cstate = CS_C0;
      core_rec[k].online = 1'b1;
      core_rec[k].gov = GOV_CODE_RESET;
      core_rec[k].temp = 18'd45000;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed_ops();
    test_config_extremes();
    test_result_backpressure();
    test_drain_pause();
    test_random_traffic();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("per_core_dvfs_thermal_controller_unit: match");
    end else begin
      $display("per_core_dvfs_thermal_controller_unit: mismatch");
    end
    $finish;
  end

endmodule
